// ===== hw/rtl/vlbp_pkg.sv =====
// Package for the variable-length bit packer.
// Holds the shared constants, request codes, controller state type and the
// command/status structs between controller and datapath. No dependencies.
package vlbp_pkg;

  localparam int ByteBits       = 8;
  localparam int WordBits       = 32;
  localparam int PortCapBits    = 40;
  localparam int AccBits        = 48;
  localparam int MaxCodeBitsDef = 32;

  // Request codes carried on tuser
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } vlbp_state_e;

  typedef struct packed {
    logic load;   // take the input beat into the datapath
    logic shift;  // output beat taken, advance one byte
  } vlbp_cmd_t;

  typedef struct packed {
    logic load_empty;  // the beat being loaded produces no byte
    logic last_beat;   // the byte on the output is the final one of the run
  } vlbp_sts_t;

endpackage

// ===== hw/rtl/vlbp_ctrl.sv =====
// Controller of the variable-length bit packer.
// Two-state sequencer: take one input beat, then emit its bytes.
// Depends on vlbp_pkg.
module vlbp_ctrl
  import vlbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  vlbp_sts_t sts_i,
  output vlbp_cmd_t cmd_o
);

  vlbp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !sts_i.load_empty) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i && sts_i.last_beat) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.shift = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/vlbp_datapath.sv =====
// Datapath of the variable-length bit packer.
// Left-aligned bit accumulator, pending bit count and byte counter.
// Depends on vlbp_pkg.
module vlbp_datapath
  import vlbp_pkg::*;
#(
  parameter int MaxCodeBits = MaxCodeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vlbp_cmd_t           cmd_i,
  input  logic                req_type_i,
  input  logic [5:0]          bit_count_i,
  input  logic [WordBits-1:0] code_word_i,
  output vlbp_sts_t           sts_o,
  output logic [ByteBits-1:0] out_byte_o
);

  localparam int CapBits = (MaxCodeBits > PortCapBits) ? PortCapBits : MaxCodeBits;
  localparam logic [5:0] CapVal = 6'(CapBits);

  // Top byte of the accumulator holds the pending bits while idle, zero-padded.
  logic [AccBits-1:0] sr_q, sr_d;
  logic [2:0]         pcnt_q, pcnt_d;
  logic [2:0]         bytes_q, bytes_d;

  logic [5:0]         count;
  logic [6:0]         shamt;
  logic [AccBits-1:0] word_ext;
  logic [AccBits-1:0] word_sh;
  logic [AccBits-1:0] aligned;
  logic [5:0]         total;

  always_comb begin
    count    = (bit_count_i > CapVal) ? CapVal : bit_count_i;
    shamt    = 7'(AccBits) - {1'b0, count};
    word_ext = {{(AccBits-WordBits){1'b0}}, code_word_i};
    // Left-align the code; bits above count-1 drop off the top.
    word_sh  = word_ext << shamt;
    aligned  = {sr_q[AccBits-1 -: ByteBits], {(AccBits-ByteBits){1'b0}}}
             | (word_sh >> pcnt_q);
    total    = 6'(pcnt_q) + count;
  end

  always_comb begin
    sts_o.load_empty = (req_type_i == REQ_FLUSH) ? (pcnt_q == 3'd0)
                                                 : (total[5:3] == 3'd0);
    sts_o.last_beat  = (bytes_q == 3'd1);
    out_byte_o       = sr_q[AccBits-1 -: ByteBits];
  end

  always_comb begin
    sr_d    = sr_q;
    pcnt_d  = pcnt_q;
    bytes_d = bytes_q;
    if (cmd_i.load) begin
      if (req_type_i == REQ_FLUSH) begin
        bytes_d = {2'b00, (pcnt_q != 3'd0)};
        pcnt_d  = 3'd0;
      end else begin
        sr_d    = aligned;
        bytes_d = total[5:3];
        pcnt_d  = total[2:0];
      end
    end else if (cmd_i.shift) begin
      sr_d    = {sr_q[AccBits-ByteBits-1:0], {ByteBits{1'b0}}};
      bytes_d = bytes_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q    <= '0;
      pcnt_q  <= '0;
      bytes_q <= '0;
    end else begin
      sr_q    <= sr_d;
      pcnt_q  <= pcnt_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

// ===== hw/rtl/variable_length_bit_packer_core.sv =====
// MSB-first variable-length bit packer, stream in and byte stream out: an
// append beat adds the low bit_count bits of code_word (count saturated to
// MaxCodeBits, at most 40; bits above 31 read as zero) behind the pending
// partial byte, and a flush beat emits the pending bits left-aligned and
// zero-padded, or nothing when none are pending. tlast marks the last byte
// caused by one input beat. An item with n bytes (0 to 5) first loads the
// accumulator, then sends one byte per cycle from the output byte register
// while the output side is ready; the next input beat is taken once the last
// byte has gone.
// Depends on vlbp_pkg, vlbp_ctrl and vlbp_datapath.
module variable_length_bit_packer_core
  import vlbp_pkg::*;
#(
  parameter int MaxCodeBits = MaxCodeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [5:0] bit_count, [37:6] code_word, [39:38] zero
  input  logic        s_axis_tuser_i,   // [0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o    // last_of_run
);

  vlbp_cmd_t cmd;
  vlbp_sts_t sts;

  vlbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vlbp_datapath #(
    .MaxCodeBits (MaxCodeBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_type_i  (s_axis_tuser_i),
    .bit_count_i (s_axis_tdata_i[5:0]),
    .code_word_i (s_axis_tdata_i[37:6]),
    .sts_o       (sts),
    .out_byte_o  (m_axis_tdata_o)
  );

  assign m_axis_tlast_o = sts.last_beat;

  // Input and output sides never run at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while bytes are pending");

  // A run keeps going until its tlast beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("byte run ended without tlast");

  // After the tlast beat the block takes input again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("not ready after last byte");

endmodule
